// ===== sv/hoode_pkg.sv =====
`timescale 1ns / 1ps

package hoode_pkg;

    // Geometry and number format
    localparam int AXES       = 3;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    localparam int STEP_BITS  = 24;
    localparam int METHOD_W   = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_BIT = 2;

    // Stream payload
    localparam int STATE_W = 2 * AXES * DATA_WIDTH;
    localparam int TDATA_W = ((STATE_W + 7) / 8) * 8;

    // Datapath widths
    localparam int OP_W   = DATA_WIDTH + 2;              // multiplier operand
    localparam int PROD_W = STEP_BITS + 1 + OP_W;        // h * operand
    localparam int K_W    = PROD_W - FRAC_BITS;          // rounded slope term
    localparam int ACC_W  = K_W + 3;                     // weighted slope sum

    // Divide-by-six unit
    localparam int DIV_W     = DATA_WIDTH + 4;
    localparam int DIV_BITS  = 9;
    localparam int DIV_STEPS = (DIV_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_PAD   = DIV_STEPS * DIV_BITS;
    localparam int REM_W     = 3;
    localparam logic [REM_W:0] DIVISOR = 4'd6;

    // Register map
    localparam logic REG_METHOD = 1'b0;
    localparam logic REG_STEP   = 1'b1;

    localparam logic [METHOD_W-1:0]  METHOD_EULER    = 2'd0;
    localparam logic [METHOD_W-1:0]  METHOD_MIDPOINT = 2'd1;
    localparam logic [METHOD_W-1:0]  METHOD_RK4      = 2'd2;
    localparam logic [METHOD_W-1:0]  METHOD_RESET    = METHOD_RK4;
    localparam logic [STEP_BITS-1:0] STEP_RESET      = 24'd167772;

    // Input beat kind
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Slope terms in the order the lane multiplier produces them
    localparam logic [2:0] K1X = 3'd0;
    localparam logic [2:0] K1V = 3'd1;
    localparam logic [2:0] K2V = 3'd2;
    localparam logic [2:0] K2X = 3'd3;
    localparam logic [2:0] K3X = 3'd4;
    localparam logic [2:0] K3V = 3'd5;
    localparam logic [2:0] K4V = 3'd6;
    localparam logic [2:0] K4X = 3'd7;

    // Accumulation weights
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_ONE  = 2'd1;
    localparam logic [1:0] W_TWO  = 2'd2;

    // Control from the sequencer to every lane
    typedef struct packed {
        logic                load;
        logic                start;
        logic                first;
        logic                rnd_valid;
        logic [2:0]          rnd_idx;
        logic [METHOD_W-1:0] method;
        logic                rk4;
        logic                div_load;
        logic                div_step;
        logic                update;
    } lane_ctrl_t;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [DIV_PAD-1:0] dvd;
    } div_state_t;

    // Weight of slope term idx in the step sum for the given scheme
    function automatic logic [1:0] k_weight(input logic [METHOD_W-1:0] method,
                                            input logic [2:0] idx);
        logic [1:0] w;
        w = W_NONE;
        case (method)
            METHOD_EULER: begin
                if (idx == K1X || idx == K1V) w = W_ONE;
            end
            METHOD_MIDPOINT: begin
                if (idx == K2X || idx == K2V) w = W_ONE;
            end
            default: begin
                if (idx == K1X || idx == K1V || idx == K4X || idx == K4V) w = W_ONE;
                else w = W_TWO;
            end
        endcase
        return w;
    endfunction

    // Position-side slope terms
    function automatic logic k_is_x(input logic [2:0] idx);
        return (idx == K1X || idx == K2X || idx == K3X || idx == K4X);
    endfunction

    // Last slope term a scheme needs
    function automatic logic [2:0] last_k(input logic [METHOD_W-1:0] method);
        logic [2:0] r;
        case (method)
            METHOD_EULER:    r = K1V;
            METHOD_MIDPOINT: r = K2X;
            default:         r = K4X;
        endcase
        return r;
    endfunction

    // DIV_BITS restoring steps of an unsigned divide by six; the quotient
    // bits shift into the bottom as the dividend leaves the top
    function automatic div_state_t div6_step(input div_state_t cur);
        div_state_t nxt;
        logic [REM_W:0] t;
        nxt = cur;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {nxt.rem, nxt.dvd[DIV_PAD-1]};
            nxt.dvd = {nxt.dvd[DIV_PAD-2:0], 1'b0};
            if (t >= DIVISOR) begin
                nxt.rem    = REM_W'(t - DIVISOR);
                nxt.dvd[0] = 1'b1;
            end else begin
                nxt.rem = t[REM_W-1:0];
            end
        end
        return nxt;
    endfunction

endpackage

// ===== sv/harmonic_oscillator_ode_stepper.sv =====
`timescale 1ns / 1ps

// Three-axis unit harmonic oscillator stepper (a = -x), state in signed Q8.24.
// Input beats: s_tuser = 0 loads position/velocity from s_tdata and echoes it,
// s_tuser = 1 advances every axis by one step of size h and emits the result.
// Result beats carry the state after the beat and a clamp flag in m_tuser.
// Registers on the APB port: method (0x0: 0 Euler, 1 midpoint, 2 or 3 RK4)
// and step_size (0x4: h in unsigned Q0.24). Write them only while idle.
// One beat is worked at a time. Each axis has its own lane with one
// multiplier that produces one slope term per cycle, so a step needs 2, 4
// or 8 slope terms; RK4 then runs a divide-by-six that retires 9 quotient
// bits per cycle. The block is ready for the next beat in the cycle after
// the result is registered.
// If m_tready is low the result stays in the output register and the block
// holds its next result until that slot frees, taking no input meanwhile.
// Reset (aresetn low, synchronous) zeroes the state, empties the output
// register and restores method = RK4, step_size = 167772.

module harmonic_oscillator_ode_stepper import hoode_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (lowest first)
    input  logic [TDATA_W-1:0]    s_tdata,
    // mode
    input  logic                  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
    output logic [TDATA_W-1:0]    m_tdata,
    // saturated
    output logic                  m_tuser
);

    logic [METHOD_W-1:0]  method_reg, method_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 cfg_write;
    logic                 out_free;
    logic                 out_load;
    lane_ctrl_t           lane_ctrl;

    logic signed [DATA_WIDTH-1:0] lane_pos [AXES];
    logic signed [DATA_WIDTH-1:0] lane_vel [AXES];
    logic [AXES-1:0]              lane_sat;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        method_next = method_reg;
        step_next   = step_reg;
        if (cfg_write) begin
            unique case (paddr[REG_IDX_BIT])
                REG_METHOD: method_next = pwdata[METHOD_W-1:0];
                REG_STEP:   step_next   = pwdata[STEP_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_IDX_BIT])
            REG_METHOD: prdata = CFG_DATA_W'(method_reg);
            REG_STEP:   prdata = CFG_DATA_W'(step_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= METHOD_RESET;
            step_reg   <= STEP_RESET;
        end else begin
            method_reg <= method_next;
            step_reg   <= step_next;
        end
    end

    // Sequencer
    assign out_free = !m_tvalid_reg || m_tready;

    hoode_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_mode    (s_tuser),
        .method    (method_reg),
        .out_free  (out_free),
        .s_tready  (s_tready),
        .out_load  (out_load),
        .lane_ctrl (lane_ctrl)
    );

    // One lane per axis
    for (genvar i = 0; i < AXES; i++) begin : g_lane
        hoode_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .step_size (step_reg),
            .load_pos  (s_tdata[i*DATA_WIDTH +: DATA_WIDTH]),
            .load_vel  (s_tdata[(AXES+i)*DATA_WIDTH +: DATA_WIDTH]),
            .pos       (lane_pos[i]),
            .vel       (lane_vel[i]),
            .sat       (lane_sat[i])
        );
    end

    // Merge lanes into the output beat
    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load) begin
            m_tdata_next = '0;
            for (int i = 0; i < AXES; i++) begin
                m_tdata_next[i*DATA_WIDTH +: DATA_WIDTH]        = lane_pos[i];
                m_tdata_next[(AXES+i)*DATA_WIDTH +: DATA_WIDTH] = lane_vel[i];
            end
            m_tuser_next  = |lane_sat;
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== sv/hoode_lane.sv =====
`timescale 1ns / 1ps

module hoode_lane import hoode_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lane_ctrl_t                   ctrl,
    input  logic [STEP_BITS-1:0]         step_size,
    input  logic signed [DATA_WIDTH-1:0] load_pos,
    input  logic signed [DATA_WIDTH-1:0] load_vel,
    output logic signed [DATA_WIDTH-1:0] pos,
    output logic signed [DATA_WIDTH-1:0] vel,
    output logic                         sat
);

    localparam logic signed [PROD_W-1:0] HALF_NARROW = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] HALF_WIDE   = PROD_W'(1) <<< FRAC_BITS;
    // 6 * 2^DATA_WIDTH keeps the dividend positive; +3 rounds the sum
    localparam logic signed [ACC_W-1:0] DIV_BIAS =
        ACC_W'({3'b110, {DATA_WIDTH{1'b0}}}) + ACC_W'(3);
    localparam logic signed [ACC_W-1:0] Q_OFFSET = ACC_W'({1'b1, {DATA_WIDTH{1'b0}}});
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_MIN  =
        {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic signed [DATA_WIDTH-1:0] x_reg, x_next;
    logic signed [DATA_WIDTH-1:0] v_reg, v_next;
    logic                         sat_reg, sat_next;
    logic signed [OP_W-1:0]       op_reg, op_next;
    logic signed [PROD_W-1:0]     p_reg;
    logic signed [ACC_W-1:0]      acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0]      acc_v_reg, acc_v_next;
    div_state_t                   div_x_reg, div_x_next;
    div_state_t                   div_v_reg, div_v_next;

    logic signed [STEP_BITS:0]    h_s;
    logic signed [PROD_W-1:0]     prod;
    logic                         wide_shift;
    logic signed [PROD_W-1:0]     rsum;
    logic signed [K_W-1:0]        k;
    logic signed [K_W-1:0]        op_sum;
    logic                         op_neg;
    logic signed [ACC_W-1:0]      k_ext;
    logic signed [ACC_W-1:0]      k_weighted;
    logic signed [ACC_W-1:0]      d_x, d_v;
    logic signed [ACC_W-1:0]      new_x, new_v;

    // One multiplier per lane: h times the staged operand
    assign h_s  = $signed({1'b0, step_size});
    assign prod = PROD_W'(h_s) * PROD_W'(op_reg);

    // Round half up; the midpoint terms drop one more bit
    always_comb begin
        wide_shift = (ctrl.rnd_idx == K2V) || (ctrl.rnd_idx == K2X) ||
                     (ctrl.rnd_idx == K3X) || (ctrl.rnd_idx == K3V);
        rsum = p_reg + (wide_shift ? HALF_WIDE : HALF_NARROW);
        if (wide_shift) k = {rsum[PROD_W-1], rsum[PROD_W-1:FRAC_BITS+1]};
        else            k = rsum[PROD_W-1:FRAC_BITS];
    end

    // Next multiplier operand from the term just rounded
    always_comb begin
        op_sum = k;
        op_neg = 1'b0;
        unique case (ctrl.rnd_idx)
            K1X: begin op_sum = (K_W'(x_reg) <<< 1) + k; op_neg = 1'b1; end
            K1V: begin op_sum = (K_W'(v_reg) <<< 1) + k; op_neg = 1'b0; end
            K2V: begin op_sum = (K_W'(v_reg) <<< 1) + k; op_neg = 1'b0; end
            K2X: begin op_sum = (K_W'(x_reg) <<< 1) + k; op_neg = 1'b1; end
            K3X: begin op_sum = K_W'(x_reg) + k;         op_neg = 1'b1; end
            K3V: begin op_sum = K_W'(v_reg) + k;         op_neg = 1'b0; end
            K4V: begin op_sum = k;                       op_neg = 1'b0; end
            K4X: begin op_sum = k;                       op_neg = 1'b0; end
        endcase
    end

    always_comb begin
        op_next = op_reg;
        if (ctrl.start)          op_next = OP_W'(v_reg);
        else if (ctrl.first)     op_next = -OP_W'(x_reg);
        else if (ctrl.rnd_valid) op_next = OP_W'(op_neg ? -op_sum : op_sum);
    end

    // Weighted slope sums
    always_comb begin
        k_ext = ACC_W'(k);
        unique case (k_weight(ctrl.method, ctrl.rnd_idx))
            W_ONE:   k_weighted = k_ext;
            W_TWO:   k_weighted = k_ext <<< 1;
            default: k_weighted = '0;
        endcase
        acc_x_next = acc_x_reg;
        acc_v_next = acc_v_reg;
        if (ctrl.start) begin
            acc_x_next = '0;
            acc_v_next = '0;
        end else if (ctrl.rnd_valid) begin
            if (k_is_x(ctrl.rnd_idx)) acc_x_next = acc_x_reg + k_weighted;
            else                      acc_v_next = acc_v_reg + k_weighted;
        end
    end

    // Floor divide by six for the RK4 sum
    always_comb begin
        div_x_next = div_x_reg;
        div_v_next = div_v_reg;
        if (ctrl.div_load) begin
            div_x_next.rem = '0;
            div_x_next.dvd = DIV_PAD'(acc_x_reg + DIV_BIAS);
            div_v_next.rem = '0;
            div_v_next.dvd = DIV_PAD'(acc_v_reg + DIV_BIAS);
        end else if (ctrl.div_step) begin
            div_x_next = div6_step(div_x_reg);
            div_v_next = div6_step(div_v_reg);
        end
    end

    // New state with clamping
    always_comb begin
        if (ctrl.rk4) begin
            d_x = $signed(ACC_W'(div_x_reg.dvd)) - Q_OFFSET;
            d_v = $signed(ACC_W'(div_v_reg.dvd)) - Q_OFFSET;
        end else begin
            d_x = acc_x_reg;
            d_v = acc_v_reg;
        end
        new_x = ACC_W'(x_reg) + d_x;
        new_v = ACC_W'(v_reg) + d_v;

        x_next   = x_reg;
        v_next   = v_reg;
        sat_next = sat_reg;
        if (ctrl.load) begin
            x_next   = load_pos;
            v_next   = load_vel;
            sat_next = 1'b0;
        end else if (ctrl.start) begin
            sat_next = 1'b0;
        end else if (ctrl.update) begin
            if (new_x > SAT_MAX)      x_next = DATA_WIDTH'(SAT_MAX);
            else if (new_x < SAT_MIN) x_next = DATA_WIDTH'(SAT_MIN);
            else                      x_next = DATA_WIDTH'(new_x);
            if (new_v > SAT_MAX)      v_next = DATA_WIDTH'(SAT_MAX);
            else if (new_v < SAT_MIN) v_next = DATA_WIDTH'(SAT_MIN);
            else                      v_next = DATA_WIDTH'(new_v);
            sat_next = (new_x > SAT_MAX) || (new_x < SAT_MIN) ||
                       (new_v > SAT_MAX) || (new_v < SAT_MIN);
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg   <= '0;
            v_reg   <= '0;
            sat_reg <= 1'b0;
        end else begin
            x_reg   <= x_next;
            v_reg   <= v_next;
            sat_reg <= sat_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        p_reg     <= prod;
        acc_x_reg <= acc_x_next;
        acc_v_reg <= acc_v_next;
        div_x_reg <= div_x_next;
        div_v_reg <= div_v_next;
    end

    assign pos = x_reg;
    assign vel = v_reg;
    assign sat = sat_reg;

endmodule

// ===== sv/hoode_ctrl.sv =====
`timescale 1ns / 1ps

module hoode_ctrl import hoode_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_mode,
    input  logic [METHOD_W-1:0] method,
    input  logic                out_free,
    output logic                s_tready,
    output logic                out_load,
    output lane_ctrl_t          lane_ctrl
);

    localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_ROUND,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_UPDATE,
        ST_SEND
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           rnd_cnt_reg, rnd_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 accept;
    logic                 rk4;

    assign rk4    = (method != METHOD_EULER) && (method != METHOD_MIDPOINT);
    assign accept = s_tvalid && (state_reg == ST_IDLE);

    // Lane control decode
    always_comb begin
        s_tready            = (state_reg == ST_IDLE);
        out_load            = (state_reg == ST_SEND) && out_free;
        lane_ctrl.load      = accept && (s_mode == MODE_LOAD);
        lane_ctrl.start     = accept && (s_mode == MODE_STEP);
        lane_ctrl.first     = (state_reg == ST_FIRST);
        lane_ctrl.rnd_valid = (state_reg == ST_ROUND);
        lane_ctrl.rnd_idx   = rnd_cnt_reg;
        lane_ctrl.method    = method;
        lane_ctrl.rk4       = rk4;
        lane_ctrl.div_load  = (state_reg == ST_DIV_LOAD);
        lane_ctrl.div_step  = (state_reg == ST_DIV_STEP);
        lane_ctrl.update    = (state_reg == ST_UPDATE);
    end

    // Sequencing
    always_comb begin
        state_next   = state_reg;
        rnd_cnt_next = rnd_cnt_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == MODE_STEP) state_next = ST_FIRST;
                    else                     state_next = ST_SEND;
                end
            end
            ST_FIRST: begin
                rnd_cnt_next = K1X;
                state_next   = ST_ROUND;
            end
            ST_ROUND: begin
                if (rnd_cnt_reg == last_k(method)) begin
                    state_next = rk4 ? ST_DIV_LOAD : ST_UPDATE;
                end else begin
                    rnd_cnt_next = rnd_cnt_reg + 3'd1;
                end
            end
            ST_DIV_LOAD: begin
                div_cnt_next = '0;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                if (div_cnt_reg == DIV_LAST) state_next = ST_UPDATE;
                else div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_UPDATE: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            rnd_cnt_reg <= rnd_cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule
